// ----- src/tlsc_pkg.sv -----
// Shared types, constants and the solve microprogram of the touch calibration block.
package tlsc_pkg;

  localparam int MAX_POINTS = 16;
  localparam int CNT_W = 5;
  localparam int NUM_SUMS = 11;
  localparam int RF_DEPTH = 32;
  localparam int RF_AW = 5;
  localparam int QDEPTH = 2;
  localparam int QAW = 1;
  localparam int PROG_LEN = 47;
  localparam int PC_W = 6;

  localparam logic [1:0] STATUS_CONV     = 2'd0;
  localparam logic [1:0] STATUS_DONE     = 2'd1;
  localparam logic [1:0] STATUS_SINGULAR = 2'd2;
  localparam logic [1:0] STATUS_NOCAL    = 2'd3;

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_LAST  = 2'd1;
  localparam logic [1:0] KIND_CONV  = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;
  localparam logic [12:0] WIDTH_RST  = 13'd800;
  localparam logic [12:0] HEIGHT_RST = 13'd480;

  // register file map
  localparam logic [4:0] RI_A   = 5'd0;
  localparam logic [4:0] RI_B   = 5'd1;
  localparam logic [4:0] RI_C   = 5'd2;
  localparam logic [4:0] RI_D   = 5'd3;
  localparam logic [4:0] RI_E   = 5'd4;
  localparam logic [4:0] RI_X1  = 5'd5;
  localparam logic [4:0] RI_Y1  = 5'd8;
  localparam logic [4:0] RI_LASTSUM = 5'd10;
  localparam logic [4:0] RI_N   = 5'd11;
  localparam logic [4:0] RI_M0  = 5'd12;
  localparam logic [4:0] RI_M1  = 5'd13;
  localparam logic [4:0] RI_M2  = 5'd14;
  localparam logic [4:0] RI_Q   = 5'd15;
  localparam logic [4:0] RI_R   = 5'd16;
  localparam logic [4:0] RI_U   = 5'd17;
  localparam logic [4:0] RI_W   = 5'd18;
  localparam logic [4:0] RI_DX1 = 5'd19;
  localparam logic [4:0] RI_DY1 = 5'd22;
  localparam logic [4:0] RI_DD  = 5'd25;

  localparam logic [2:0] SEL_TX  = 3'd0;
  localparam logic [2:0] SEL_TY  = 3'd1;
  localparam logic [2:0] SEL_SX  = 3'd2;
  localparam logic [2:0] SEL_SY  = 3'd3;
  localparam logic [2:0] SEL_ONE = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] tx;
    logic [11:0] ty;
    logic [11:0] sx;
    logic [11:0] sy;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [79:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [11:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic       clr;
    logic       sub;
    logic       wr;
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] dest;
  } uop_t;

  typedef struct packed {
    logic [2:0] a;
    logic [2:0] b;
  } term_t;

  function automatic uop_t uop(input logic clr, input logic sub, input logic wr,
                               input logic [4:0] a, input logic [4:0] b,
                               input logic [4:0] dest);
    uop_t u;
    u.clr = clr;
    u.sub = sub;
    u.wr = wr;
    u.a = a;
    u.b = b;
    u.dest = dest;
    return u;
  endfunction

  // numerators of one axis: p1..p3 are the sums with the target coordinate
  function automatic uop_t axis_uop(input logic [4:0] s, input logic ax);
    logic [4:0] p1;
    logic [4:0] p2;
    logic [4:0] p3;
    logic [4:0] d1;
    uop_t u;
    p1 = ax ? RI_Y1 : RI_X1;
    p2 = p1 + 5'd1;
    p3 = p1 + 5'd2;
    d1 = ax ? RI_DY1 : RI_DX1;
    case (s)
      5'd0:  u = uop(1'b1, 1'b0, 1'b0, p1, RI_B, RI_A);
      5'd1:  u = uop(1'b0, 1'b1, 1'b1, p2, RI_C, RI_Q);
      5'd2:  u = uop(1'b1, 1'b0, 1'b0, p2, RI_D, RI_A);
      5'd3:  u = uop(1'b0, 1'b1, 1'b1, p1, RI_E, RI_R);
      5'd4:  u = uop(1'b1, 1'b0, 1'b0, RI_N, RI_Q, RI_A);
      5'd5:  u = uop(1'b0, 1'b0, 1'b0, RI_E, RI_R, RI_A);
      5'd6:  u = uop(1'b0, 1'b0, 1'b1, p3, RI_M1, d1);
      5'd7:  u = uop(1'b1, 1'b0, 1'b0, p2, RI_A, RI_A);
      5'd8:  u = uop(1'b0, 1'b1, 1'b1, p1, RI_C, RI_Q);
      5'd9:  u = uop(1'b1, 1'b0, 1'b0, p1, RI_E, RI_A);
      5'd10: u = uop(1'b0, 1'b1, 1'b1, p2, RI_D, RI_R);
      5'd11: u = uop(1'b1, 1'b0, 1'b0, RI_N, RI_Q, RI_A);
      5'd12: u = uop(1'b0, 1'b0, 1'b0, RI_D, RI_R, RI_A);
      5'd13: u = uop(1'b0, 1'b0, 1'b1, p3, RI_M2, d1 + 5'd1);
      5'd14: u = uop(1'b1, 1'b0, 1'b0, p3, RI_M0, RI_A);
      5'd15: u = uop(1'b0, 1'b0, 1'b0, p1, RI_M1, RI_A);
      default: u = uop(1'b0, 1'b0, 1'b1, p2, RI_M2, d1 + 5'd2);
    endcase
    return u;
  endfunction

  function automatic uop_t prog(input logic [PC_W-1:0] pc);
    uop_t u;
    if (pc < 6'd10) begin
      case (pc)
        6'd0: u = uop(1'b1, 1'b0, 1'b0, RI_A, RI_B, RI_A);
        6'd1: u = uop(1'b0, 1'b1, 1'b1, RI_C, RI_C, RI_M0);
        6'd2: u = uop(1'b1, 1'b0, 1'b0, RI_C, RI_E, RI_A);
        6'd3: u = uop(1'b0, 1'b1, 1'b1, RI_B, RI_D, RI_M1);
        6'd4: u = uop(1'b1, 1'b0, 1'b0, RI_C, RI_D, RI_A);
        6'd5: u = uop(1'b0, 1'b1, 1'b1, RI_A, RI_E, RI_M2);
        6'd6: u = uop(1'b1, 1'b0, 1'b0, RI_C, RI_D, RI_A);
        6'd7: u = uop(1'b0, 1'b0, 1'b0, RI_C, RI_D, RI_A);
        6'd8: u = uop(1'b0, 1'b1, 1'b1, RI_A, RI_E, RI_U);
        default: u = uop(1'b1, 1'b0, 1'b1, RI_D, RI_D, RI_W);
      endcase
    end else if (pc < 6'd27) begin
      u = axis_uop(5'(pc - 6'd10), 1'b0);
    end else if (pc < 6'd44) begin
      u = axis_uop(5'(pc - 6'd27), 1'b1);
    end else begin
      case (pc)
        6'd44: u = uop(1'b1, 1'b0, 1'b0, RI_N, RI_M0, RI_A);
        6'd45: u = uop(1'b0, 1'b0, 1'b0, RI_E, RI_U, RI_A);
        default: u = uop(1'b0, 1'b1, 1'b1, RI_B, RI_W, RI_DD);
      endcase
    end
    return u;
  endfunction

  function automatic term_t acc_term(input logic [3:0] i);
    term_t t;
    case (i)
      4'd0: t = '{SEL_TX, SEL_TX};
      4'd1: t = '{SEL_TY, SEL_TY};
      4'd2: t = '{SEL_TX, SEL_TY};
      4'd3: t = '{SEL_TX, SEL_ONE};
      4'd4: t = '{SEL_TY, SEL_ONE};
      4'd5: t = '{SEL_TX, SEL_SX};
      4'd6: t = '{SEL_TY, SEL_SX};
      4'd7: t = '{SEL_SX, SEL_ONE};
      4'd8: t = '{SEL_TX, SEL_SY};
      4'd9: t = '{SEL_TY, SEL_SY};
      default: t = '{SEL_SY, SEL_ONE};
    endcase
    return t;
  endfunction

  function automatic logic [12:0] clamp_lim(input logic [12:0] size);
    logic [12:0] l;
    if (size == 13'd0) l = 13'd1;
    else if (size > 13'd4096) l = 13'd4096;
    else l = size;
    return l;
  endfunction

endpackage

// ----- src/tlsc_item_if.sv -----
// Request channel carrying calibration and convert items.
interface tlsc_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [11:0] touch_x;
  logic [11:0] touch_y;
  logic [11:0] target_x;
  logic [11:0] target_y;
  logic        last_point;

  modport source (output valid, op, touch_x, touch_y, target_x, target_y, last_point,
                  input ready);
  modport sink (input valid, op, touch_x, touch_y, target_x, target_y, last_point,
                output ready);
endinterface

// ----- src/tlsc_result_if.sv -----
// Result channel carrying status and converted screen point.
interface tlsc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] screen_x;
  logic [11:0] screen_y;

  modport source (output valid, status, screen_x, screen_y, input ready);
  modport sink (input valid, status, screen_x, screen_y, output ready);
endinterface

// ----- src/touch_least_squares_calibrate_top.sv -----
// Top level of the touchscreen least-squares affine calibration block.
// Usage:
//   item channel: op 0 adds a calibration point (touch and target), op 1 converts
//   a raw touch point. last_point on a calibration request ends the calibration.
//   result channel: status plus screen_x/screen_y; one result per convert and per
//   last calibration point, none for other calibration points.
//   cfg port: index 0 screen_width, index 1 screen_height, written while idle.
// Work, done by the single back-end sequencer and its one 33x33 multiplier:
//   a calibration point does 11 read-modify-writes of the sum memory; the last
//   point adds the solve, 47 multiply-accumulates, then a clear of the 11 sums;
//   a convert is dominated by two divisions. One request is processed at a time.
// A two-entry queue takes requests while the back end works; the output register
// holds a result while the receiver stalls, and the queue keeps filling.
// Reset clears the state; the back end first clears the 11 sums before taking
// requests. Before a good calibration converts report status 3.
module touch_least_squares_calibrate_top (
  input  logic          clk,
  input  logic          rst,
  tlsc_item_if.sink     item,
  tlsc_result_if.source result,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [12:0]   cfg_data
);
  tlsc_pkg::item_t q_item;
  logic q_valid;
  logic q_pop;

  tlsc_front u_front (
    .clk(clk), .rst(rst), .item(item), .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
  );

  tlsc_back u_back (
    .clk(clk), .rst(rst), .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .result(result)
  );
endmodule

// ----- src/tlsc_ram.sv -----
// Generic RAM, one write port and one registered read port.
module tlsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/tlsc_div.sv -----
// Iterative divider: 12-bit quotient with saturation flag, one bit per cycle.
module tlsc_div (
  input  logic               clk,
  input  logic               rst,
  input  tlsc_pkg::div_req_t req,
  output tlsc_pkg::div_rsp_t rsp
);
  logic        busy;
  logic [3:0]  cnt;
  logic [79:0] rem;
  logic [75:0] dsh;
  logic [11:0] quo;
  logic        sat;
  logic        done;
  logic        ge;

  assign ge = rem >= {4'b0, dsh};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 4'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 4'd13;
        rem <= req.num;
        dsh <= {req.den, 12'b0};
        quo <= 12'd0;
        sat <= 1'b0;
      end else if (busy) begin
        dsh <= dsh >> 1;
        cnt <= cnt - 4'd1;
        if (cnt == 4'd13) begin
          if (ge) begin
            sat <= 1'b1;
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          if (ge) begin
            rem <= rem - {4'b0, dsh};
          end
          quo <= {quo[10:0], ge};
          if (cnt == 4'd1) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.sat = sat;
  assign rsp.quo = quo;
endmodule

// ----- src/tlsc_front.sv -----
// Front end: accepts items, classifies them and queues them for the back end.
module tlsc_front (
  input  logic                clk,
  input  logic                rst,
  tlsc_item_if.sink           item,
  output tlsc_pkg::item_t     q_item,
  output logic                q_valid,
  input  logic                q_pop
);
  tlsc_pkg::item_t slots [tlsc_pkg::QDEPTH];
  tlsc_pkg::item_t incoming;
  logic [tlsc_pkg::QAW-1:0] wptr;
  logic [tlsc_pkg::QAW-1:0] rptr;
  logic [tlsc_pkg::QAW:0]   fill;
  logic push;
  logic pop;

  always_comb begin
    incoming.kind = item.op ? tlsc_pkg::KIND_CONV :
                    (item.last_point ? tlsc_pkg::KIND_LAST : tlsc_pkg::KIND_POINT);
    incoming.tx = item.touch_x;
    incoming.ty = item.touch_y;
    incoming.sx = item.target_x;
    incoming.sy = item.target_y;
  end

  assign item.ready = fill != (tlsc_pkg::QAW+1)'(tlsc_pkg::QDEPTH);
  assign push = item.valid && item.ready;
  assign q_valid = fill != '0;
  assign pop = q_pop && q_valid;
  assign q_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      fill <= fill + (tlsc_pkg::QAW+1)'(push) - (tlsc_pkg::QAW+1)'(pop);
    end
  end
endmodule

// ----- src/tlsc_back.sv -----
// Back end: sum accumulation, coefficient solve sequencer and point conversion.
module tlsc_back (
  input  logic            clk,
  input  logic            rst,
  input  tlsc_pkg::item_t q_item,
  input  logic            q_valid,
  output logic            q_pop,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [12:0]     cfg_data,
  tlsc_result_if.source   result
);
  localparam logic [4:0] ST_CLR = 5'd0;
  localparam logic [4:0] ST_IDLE = 5'd1;
  localparam logic [4:0] ST_ARD = 5'd2;
  localparam logic [4:0] ST_AWR = 5'd3;
  localparam logic [4:0] ST_SA = 5'd4;
  localparam logic [4:0] ST_SB = 5'd5;
  localparam logic [4:0] ST_M1 = 5'd6;
  localparam logic [4:0] ST_M2 = 5'd7;
  localparam logic [4:0] ST_M3 = 5'd8;
  localparam logic [4:0] ST_M4 = 5'd9;
  localparam logic [4:0] ST_M5 = 5'd10;
  localparam logic [4:0] ST_CR = 5'd11;
  localparam logic [4:0] ST_C1 = 5'd12;
  localparam logic [4:0] ST_C2 = 5'd13;
  localparam logic [4:0] ST_C3 = 5'd14;
  localparam logic [4:0] ST_DR = 5'd15;
  localparam logic [4:0] ST_DS = 5'd16;
  localparam logic [4:0] ST_DW = 5'd17;
  localparam logic [4:0] ST_OUT = 5'd18;

  logic [4:0] state;
  logic [4:0] after;
  tlsc_pkg::item_t cur;
  logic [tlsc_pkg::CNT_W-1:0] count;
  logic calibrated;
  logic [3:0] idx;
  logic [tlsc_pkg::PC_W-1:0] pc;
  logic ax;
  logic [1:0] j;
  logic neg;
  logic [63:0] opa;
  logic [63:0] opb;
  logic [63:0] pacc;
  logic [63:0] macc;
  logic signed [79:0] cacc;
  logic signed [65:0] mreg;
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic [12:0] width;
  logic [12:0] height;
  logic [1:0] res_status;
  logic [11:0] res_x;
  logic [11:0] res_y;

  logic we;
  logic [tlsc_pkg::RF_AW-1:0] waddr;
  logic [63:0] wdata;
  logic [tlsc_pkg::RF_AW-1:0] raddr;
  logic [63:0] rdata;

  tlsc_pkg::uop_t u;
  tlsc_pkg::term_t term;
  tlsc_pkg::div_req_t dreq;
  tlsc_pkg::div_rsp_t drsp;
  logic [63:0] n64;
  logic [63:0] prod;
  logic [63:0] macc_next;
  logic [4:0] cbase;
  logic [11:0] tval;
  logic [12:0] lim;
  logic [11:0] axis_val;
  logic signed [79:0] mext;

  tlsc_ram #(.WIDTH(64), .DEPTH(tlsc_pkg::RF_DEPTH)) u_rf (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  tlsc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  function automatic logic [11:0] pick(input logic [2:0] sel, input tlsc_pkg::item_t it);
    logic [11:0] v;
    case (sel)
      tlsc_pkg::SEL_TX: v = it.tx;
      tlsc_pkg::SEL_TY: v = it.ty;
      tlsc_pkg::SEL_SX: v = it.sx;
      tlsc_pkg::SEL_SY: v = it.sy;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  assign u = tlsc_pkg::prog(pc);
  assign term = tlsc_pkg::acc_term(idx);
  assign n64 = 64'(count);
  assign prod = pacc + {mreg[31:0], 32'b0};
  assign macc_next = (u.clr ? 64'd0 : macc) + (u.sub ? (64'd0 - prod) : prod);
  assign cbase = (ax ? tlsc_pkg::RI_DY1 : tlsc_pkg::RI_DX1) + {3'b0, j};
  assign tval = (j == 2'd0) ? cur.tx : ((j == 2'd1) ? cur.ty : 12'd1);
  assign lim = tlsc_pkg::clamp_lim(ax ? height : width);
  assign mext = 80'(mreg);
  assign q_pop = (state == ST_IDLE) && q_valid;

  always_comb begin
    if (neg) axis_val = 12'd0;
    else if (drsp.sat || ({1'b0, drsp.quo} >= lim)) axis_val = 12'(lim - 13'd1);
    else axis_val = drsp.quo;
  end

  always_comb begin
    dreq.start = state == ST_DS;
    dreq.num = cacc[79] ? 80'(-cacc) : 80'(cacc);
    dreq.den = rdata[63] ? (64'd0 - rdata) : rdata;
  end

  always_comb begin
    raddr = '0;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    ma = '0;
    mb = '0;
    case (state)
      ST_CLR: begin
        we = 1'b1;
        waddr = {1'b0, idx};
      end
      ST_ARD: begin
        raddr = {1'b0, idx};
        ma = {21'b0, pick(term.a, cur)};
        mb = {21'b0, pick(term.b, cur)};
      end
      ST_AWR: begin
        we = 1'b1;
        waddr = {1'b0, idx};
        wdata = {32'b0, rdata[31:0] + mreg[31:0]};
      end
      ST_SA: raddr = u.a;
      ST_SB: raddr = u.b;
      ST_M2: begin
        ma = {1'b0, opa[31:0]};
        mb = {1'b0, opb[31:0]};
      end
      ST_M3: begin
        ma = {1'b0, opa[31:0]};
        mb = {1'b0, opb[63:32]};
      end
      ST_M4: begin
        ma = {1'b0, opa[63:32]};
        mb = {1'b0, opb[31:0]};
      end
      ST_M5: begin
        we = u.wr;
        waddr = u.dest;
        wdata = macc_next;
      end
      ST_CR: raddr = cbase;
      ST_C1: begin
        raddr = cbase;
        ma = {21'b0, tval};
        mb = {1'b0, rdata[31:0]};
      end
      ST_C2: begin
        raddr = cbase;
        ma = {21'b0, tval};
        mb = {rdata[63], rdata[63:32]};
      end
      ST_DR, ST_DS: raddr = tlsc_pkg::RI_DD;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mreg <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width <= tlsc_pkg::WIDTH_RST;
      height <= tlsc_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      if (cfg_index == tlsc_pkg::CFG_WIDTH) width <= cfg_data;
      else height <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      after <= ST_IDLE;
      idx <= 4'd0;
      count <= '0;
      calibrated <= 1'b0;
      pc <= '0;
      ax <= 1'b0;
      j <= 2'd0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != ST_OUT) result.valid <= 1'b0;
      unique case (state)
        ST_CLR: begin
          if (idx == tlsc_pkg::RI_LASTSUM[3:0]) begin
            idx <= 4'd0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + 4'd1;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            if (q_item.kind == tlsc_pkg::KIND_CONV) begin
              if (calibrated) begin
                ax <= 1'b0;
                j <= 2'd0;
                cacc <= '0;
                state <= ST_CR;
              end else begin
                res_status <= tlsc_pkg::STATUS_NOCAL;
                res_x <= 12'd0;
                res_y <= 12'd0;
                after <= ST_IDLE;
                state <= ST_OUT;
              end
            end else if (count < tlsc_pkg::CNT_W'(tlsc_pkg::MAX_POINTS)) begin
              idx <= 4'd0;
              state <= ST_ARD;
            end else if (q_item.kind == tlsc_pkg::KIND_LAST) begin
              pc <= '0;
              state <= ST_SA;
            end
          end
        end
        ST_ARD: state <= ST_AWR;
        ST_AWR: begin
          if (idx == tlsc_pkg::RI_LASTSUM[3:0]) begin
            idx <= 4'd0;
            count <= count + 1'b1;
            pc <= '0;
            state <= (cur.kind == tlsc_pkg::KIND_LAST) ? ST_SA : ST_IDLE;
          end else begin
            idx <= idx + 4'd1;
            state <= ST_ARD;
          end
        end
        ST_SA: state <= ST_SB;
        ST_SB: begin
          opa <= (u.a == tlsc_pkg::RI_N) ? n64 : rdata;
          state <= ST_M1;
        end
        ST_M1: begin
          opb <= (u.b == tlsc_pkg::RI_N) ? n64 : rdata;
          state <= ST_M2;
        end
        ST_M2: state <= ST_M3;
        ST_M3: begin
          pacc <= mreg[63:0];
          state <= ST_M4;
        end
        ST_M4: begin
          pacc <= pacc + {mreg[31:0], 32'b0};
          state <= ST_M5;
        end
        ST_M5: begin
          macc <= macc_next;
          if (pc == tlsc_pkg::PC_W'(tlsc_pkg::PROG_LEN - 1)) begin
            calibrated <= macc_next != 64'd0;
            res_status <= (macc_next != 64'd0) ? tlsc_pkg::STATUS_DONE
                                               : tlsc_pkg::STATUS_SINGULAR;
            res_x <= 12'd0;
            res_y <= 12'd0;
            count <= '0;
            idx <= 4'd0;
            after <= ST_CLR;
            state <= ST_OUT;
          end else begin
            pc <= pc + 1'b1;
            state <= ST_SA;
          end
        end
        ST_CR: state <= ST_C1;
        ST_C1: state <= ST_C2;
        ST_C2: begin
          cacc <= cacc + mext;
          state <= ST_C3;
        end
        ST_C3: begin
          cacc <= cacc + (mext <<< 32);
          if (j == 2'd2) begin
            j <= 2'd0;
            state <= ST_DR;
          end else begin
            j <= j + 2'd1;
            state <= ST_CR;
          end
        end
        ST_DR: state <= ST_DS;
        ST_DS: begin
          neg <= cacc[79] ^ rdata[63];
          state <= ST_DW;
        end
        ST_DW: begin
          if (drsp.done) begin
            if (!ax) begin
              res_x <= axis_val;
              ax <= 1'b1;
              cacc <= '0;
              state <= ST_CR;
            end else begin
              res_y <= axis_val;
              res_status <= tlsc_pkg::STATUS_CONV;
              after <= ST_IDLE;
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (!result.valid || result.ready) begin
            result.valid <= 1'b1;
            result.status <= res_status;
            result.screen_x <= res_x;
            result.screen_y <= res_y;
            state <= after;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- src/tlsc_checker.sv -----
// Port-level checker for the calibration block and its bind.
module tlsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  res_status,
  input logic [11:0] res_x,
  input logic [11:0] res_y
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != tlsc_pkg::STATUS_CONV |-> res_x == 12'd0 && res_y == 12'd0)
    else $error("nonzero point on status result");

  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid && in_ready)
    else $error("bad state after reset");
endmodule

bind touch_least_squares_calibrate_top tlsc_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(item.ready), .res_valid(result.valid),
  .res_ready(result.ready), .res_status(result.status), .res_x(result.screen_x),
  .res_y(result.screen_y)
);
